[design/gpc_pkg.sv]
// ----------------------------------------------------------------------------
// gpc_pkg
// Shared constants, types and elaboration-time tables for the gamma block:
// log2 of every grey level and the exp2 step constants, all in Q30.
// ----------------------------------------------------------------------------
package gpc_pkg;

    localparam int GAMMA_DENOM = 40;
    localparam int FRAC_BITS   = 30;
    localparam int PIX_W       = 8;
    localparam int PIX_DEPTH   = 1 << PIX_W;
    localparam int GAMMA_W     = 8;
    localparam int LOG_W       = FRAC_BITS + 3;
    localparam int NUM_W       = LOG_W + GAMMA_W;
    localparam int REM_W       = $clog2(GAMMA_DENOM + 1);
    localparam int Q_W         = FRAC_BITS + 1;
    localparam int IP_W        = NUM_W - FRAC_BITS;
    localparam int DEEP_LIMIT  = 40;
    localparam int DIV_DIGITS  = (NUM_W + PIX_W - 1) / PIX_W;
    localparam int DIV_W       = DIV_DIGITS * PIX_W;
    localparam int RECIP_SH    = 24;
    localparam int DIV_RECIP   = ((1 << RECIP_SH) + GAMMA_DENOM - 1) / GAMMA_DENOM;
    localparam logic [GAMMA_W-1:0] GAMMA_RESET = GAMMA_W'(40);
    localparam logic [PIX_W-1:0]   PIX_MAX     = {PIX_W{1'b1}};

    localparam logic [Q_W-1:0] ONE_Q  = Q_W'(64'd1 << FRAC_BITS);
    localparam logic [63:0]    HALF_Q = 64'd1 << (FRAC_BITS - 1);

    typedef logic [LOG_W-1:0] log_tab_t [PIX_DEPTH];
    typedef logic [Q_W-1:0]   exp_tab_t [FRAC_BITS+1];

    typedef struct packed {
        logic             we;
        logic [PIX_W-1:0] addr;
        logic [PIX_W-1:0] data;
    } gpc_wr_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bitv;
        v    = v_in;
        res  = 64'd0;
        bitv = 64'd1 << 62;
        for (int k = 0; k < 32; k++) begin
            if (bitv > v) bitv = bitv >> 2;
        end
        for (int k = 0; k < 32; k++) begin
            if (bitv != 64'd0) begin
                if (v >= res + bitv) begin
                    v   = v - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
        end
        return res;
    endfunction

    function automatic logic [63:0] log2_q(input logic [63:0] x);
        int unsigned e;
        logic [63:0] m;
        logic [63:0] r;
        e = 0;
        for (int k = 0; k < 7; k++) begin
            if ((x >> (e + 1)) != 64'd0) e = e + 1;
        end
        m = x << (FRAC_BITS - e);
        r = 64'(e) << FRAC_BITS;
        for (int i = FRAC_BITS - 1; i >= 0; i--) begin
            m = (m * m + HALF_Q) >> FRAC_BITS;
            if (m >= (64'd2 << FRAC_BITS)) begin
                r = r | (64'd1 << i);
                m = m >> 1;
            end
        end
        return r;
    endfunction

    function automatic log_tab_t build_log_tab();
        log_tab_t t;
        t[0] = '0;
        for (int p = 1; p < PIX_DEPTH; p++) begin
            t[p] = LOG_W'(log2_q(64'(p)));
        end
        return t;
    endfunction

    function automatic exp_tab_t build_exp_tab();
        exp_tab_t t;
        logic [63:0] c;
        c    = HALF_Q;
        t[0] = ONE_Q;
        for (int i = 1; i <= FRAC_BITS; i++) begin
            c    = isqrt64(c << FRAC_BITS);
            t[i] = Q_W'(c);
        end
        return t;
    endfunction

    localparam log_tab_t LOG_TAB = build_log_tab();
    localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

[design/gpc_ram.sv]
// ----------------------------------------------------------------------------
// gpc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        if (re) rdata <= mem[raddr];
    end

endmodule

[design/gpc_fill.sv]
// ----------------------------------------------------------------------------
// gpc_fill
// Table builder: for every grey level computes the corrected value in
// fixed point (log2 lookup, gamma scale, radix-256 divide by reciprocal,
// serial exp2) and writes it into the lookup RAM.
// ----------------------------------------------------------------------------
module gpc_fill (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [gpc_pkg::GAMMA_W-1:0] gamma,
    output logic                      busy,
    output gpc_pkg::gpc_wr_t          wr
);
    import gpc_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_EXP   = 3'd3;
    localparam logic [2:0] ST_SHIFT = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    localparam logic [LOG_W-1:0] LOG_MAX = LOG_TAB[PIX_DEPTH-1];

    logic [2:0]       state_reg, state_next;
    logic [PIX_W-1:0] pix_reg, pix_next;
    logic [5:0]       cnt_reg, cnt_next;
    logic [DIV_W-1:0] num_reg, num_next;
    logic [NUM_W-1:0] quot_reg, quot_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [Q_W-1:0]   r_reg, r_next;
    logic [Q_W-1:0]   y_reg, y_next;

    logic [LOG_W-1:0]              diff;
    logic [REM_W+PIX_W-1:0]        trial;
    logic [REM_W+PIX_W+RECIP_SH:0] dprod;
    logic [PIX_W-1:0]              qdig;
    logic [2*Q_W-1:0]              prod;
    logic [IP_W-1:0]               ip;
    logic [Q_W+8:0]                scaled;
    logic [PIX_W:0]                o_full;
    logic [PIX_W-1:0]              o_val;

    always_comb begin
        diff   = LOG_MAX - LOG_TAB[pix_reg];
        trial  = {rem_reg, num_reg[DIV_W-1 -: PIX_W]};
        dprod  = (REM_W+PIX_W+RECIP_SH+1)'(trial)
                 * (REM_W+PIX_W+RECIP_SH+1)'(DIV_RECIP);
        qdig   = PIX_W'(dprod >> RECIP_SH);
        prod   = r_reg * EXP_TAB[cnt_reg[4:0]] + (2*Q_W)'(HALF_Q);
        ip     = quot_reg[NUM_W-1:FRAC_BITS];
        scaled = ({y_reg, 8'd0} - (Q_W+9)'(y_reg)) + (Q_W+9)'(HALF_Q);
        o_full = (PIX_W+1)'(scaled >> FRAC_BITS);
        o_val  = (o_full > (PIX_W+1)'(PIX_MAX)) ? PIX_MAX : o_full[PIX_W-1:0];
        if (gamma == '0) o_val = PIX_MAX;
        else if (pix_reg == '0) o_val = '0;
        else if (pix_reg == PIX_MAX) o_val = PIX_MAX;
    end

    always_comb begin
        state_next = state_reg;
        pix_next   = pix_reg;
        cnt_next   = cnt_reg;
        num_next   = num_reg;
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        r_next     = r_reg;
        y_next     = y_reg;
        wr.we      = 1'b0;
        wr.addr    = pix_reg;
        wr.data    = o_val;
        unique case (state_reg)
            ST_IDLE: begin
            end
            ST_MUL: begin
                num_next   = DIV_W'(NUM_W'(diff) * NUM_W'(gamma))
                             + DIV_W'(GAMMA_DENOM / 2);
                quot_next  = '0;
                rem_next   = '0;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                num_next  = num_reg << PIX_W;
                rem_next  = REM_W'(trial - (REM_W+PIX_W)'(qdig)
                                   * (REM_W+PIX_W)'(GAMMA_DENOM));
                quot_next = {quot_reg[NUM_W-PIX_W-1:0], qdig};
                cnt_next  = cnt_reg + 6'd1;
                if (cnt_reg == 6'(DIV_DIGITS - 1)) begin
                    cnt_next   = 6'd1;
                    r_next     = ONE_Q;
                    state_next = ST_EXP;
                end
            end
            ST_EXP: begin
                if (quot_reg[5'(FRAC_BITS - cnt_reg[4:0])]) begin
                    r_next = Q_W'(prod >> FRAC_BITS);
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(FRAC_BITS)) state_next = ST_SHIFT;
            end
            ST_SHIFT: begin
                y_next     = (ip >= IP_W'(DEEP_LIMIT)) ? '0 : (r_reg >> ip);
                state_next = ST_OUT;
            end
            ST_OUT: begin
                wr.we    = 1'b1;
                pix_next = pix_reg + 1'b1;
                state_next = (pix_reg == PIX_MAX) ? ST_IDLE : ST_MUL;
            end
            default: state_next = ST_IDLE;
        endcase
        if (start) begin
            pix_next   = '0;
            state_next = ST_MUL;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_MUL;
            pix_reg   <= '0;
        end else begin
            state_reg <= state_next;
            pix_reg   <= pix_next;
        end
        cnt_reg  <= cnt_next;
        num_reg  <= num_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        r_reg    <= r_next;
        y_reg    <= y_next;
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

[design/pixel_gamma_correction.sv]
// ----------------------------------------------------------------------------
// pixel_gamma_correction
// Gamma correction of an 8-bit grey stream through a 256-entry lookup RAM.
//
// Input beats (s_pixel_in, s_frame_end_in) arrive on s_valid/s_ready; each
// gives one output beat (m_pixel_out, m_frame_end_out) on m_valid/m_ready,
// in order, via the RAM read stage and the output register. While no build
// or stall holds it, throughput is one beat per cycle, set by the single RAM
// read port and output stage. The frame-end flag travels with its pixel.
//
// The RAM holds round(255*(p/255)^(g/40)) for every p. A builder fills it
// one entry at a time after reset (gamma 40) and after every write on
// cfg_we/cfg_wdata; s_ready stays low while it runs.
// When the receiver stalls, one beat waits in the output register and one
// in the RAM read stage; s_ready drops once both are full.
// ----------------------------------------------------------------------------
module pixel_gamma_correction (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [gpc_pkg::GAMMA_W-1:0] cfg_wdata,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [gpc_pkg::PIX_W-1:0]   s_pixel_in,
    input  logic                        s_frame_end_in,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [gpc_pkg::PIX_W-1:0]   m_pixel_out,
    output logic                        m_frame_end_out
);
    import gpc_pkg::*;

    logic [GAMMA_W-1:0] gamma_reg;
    logic               fill_busy;
    gpc_wr_t            wr;
    logic [PIX_W-1:0]   rd_data;

    logic               v1_reg, v1_next;
    logic               fe1_reg;
    logic               mv_reg, mv_next;
    logic [PIX_W-1:0]   mpix_reg;
    logic               mfe_reg;
    logic               advance, accept;

    assign advance = !mv_reg || m_ready;
    assign s_ready = !fill_busy && (!v1_reg || advance);
    assign accept  = s_valid && s_ready;

    always_comb begin
        v1_next = v1_reg;
        if (advance) v1_next = 1'b0;
        if (accept) v1_next = 1'b1;
        mv_next = mv_reg;
        if (advance) mv_next = v1_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gamma_reg <= GAMMA_RESET;
            v1_reg    <= 1'b0;
            mv_reg    <= 1'b0;
        end else begin
            if (cfg_we) gamma_reg <= cfg_wdata;
            v1_reg <= v1_next;
            mv_reg <= mv_next;
        end
        if (accept) fe1_reg <= s_frame_end_in;
        if (advance && v1_reg) begin
            mpix_reg <= rd_data;
            mfe_reg  <= fe1_reg;
        end
    end

    gpc_fill u_fill (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cfg_we),
        .gamma   (gamma_reg),
        .busy    (fill_busy),
        .wr      (wr)
    );

    gpc_ram #(
        .WIDTH (PIX_W),
        .DEPTH (PIX_DEPTH)
    ) u_lut (
        .aclk  (aclk),
        .we    (wr.we),
        .waddr (wr.addr),
        .wdata (wr.data),
        .re    (accept),
        .raddr (s_pixel_in),
        .rdata (rd_data)
    );

    assign m_valid         = mv_reg;
    assign m_pixel_out     = mpix_reg;
    assign m_frame_end_out = mfe_reg;

    a_no_accept_while_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_busy |-> !s_ready) else $error("input accepted during table build");

    a_no_write_on_read: assert property (@(posedge aclk) disable iff (!aresetn)
        !(wr.we && accept)) else $error("lookup write collides with read");

    a_cfg_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we |=> !s_ready) else $error("ready high right after gamma write");

    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && mv_reg && !m_ready) |=> v1_reg)
        else $error("read stage dropped a beat under stall");

endmodule

[dv/tb_pixel_gamma_correction.sv]
// ----------------------------------------------------------------------------
// tb_pixel_gamma_correction
// Self-checking bench for the gamma block. A local fixed-point mapper
// predicts each output pixel for the current gamma numerator. Directed
// pixels hit the extremes, black and white, zero gamma and deep exponents.
// Random pixels then run under several gamma settings, with bursty input
// and a stalling receiver.
// ----------------------------------------------------------------------------
module tb_pixel_gamma_correction;
    import gpc_pkg::*;

    localparam int Q          = 30;
    localparam int WDOG_LIMIT = 200000;

    logic               aclk;
    logic               aresetn;
    logic               cfg_we;
    logic [GAMMA_W-1:0] cfg_wdata;
    logic               s_valid;
    logic               s_ready;
    logic [PIX_W-1:0]   s_pixel_in;
    logic               s_frame_end_in;
    logic               m_valid;
    logic               m_ready;
    logic [PIX_W-1:0]   m_pixel_out;
    logic               m_frame_end_out;

    typedef struct {
        logic [PIX_W-1:0] pix;
        logic             fe;
    } pix_beat_t;

    pix_beat_t        pending_pix[$];
    logic [7:0]       cur_gamma;
    logic [63:0]      root_step[1:30];
    int               err_cnt;
    int               burst_left;
    int               idle_cycles;
    int               stall_mode;

    pixel_gamma_correction u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_pixel_in      (s_pixel_in),
        .s_frame_end_in  (s_frame_end_in),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pixel_out     (m_pixel_out),
        .m_frame_end_out (m_frame_end_out)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic logic [63:0] int_sqrt(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] b;
        v   = v_in;
        res = 0;
        b   = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] grey_log2(input logic [63:0] x);
        int          e;
        logic [63:0] m;
        logic [63:0] r;
        e = 0;
        while (e < 7 && (x >> (e + 1)) != 0) e++;
        m = x << (Q - e);
        r = 64'(e) << Q;
        for (int i = Q - 1; i >= 0; i--) begin
            m = (m * m + (64'd1 << (Q - 1))) >> Q;
            if (m >= (64'd2 << Q)) begin
                r = r | (64'd1 << i);
                m = m >> 1;
            end
        end
        return r;
    endfunction

    function automatic logic [PIX_W-1:0] gamma_map(input logic [7:0] p, input logic [7:0] g);
        logic [63:0] n;
        logic [63:0] e;
        logic [63:0] ip;
        logic [63:0] y;
        logic [63:0] o;
        if (g == 0) return 8'd255;
        if (p == 0) return 8'd0;
        if (p == 8'd255) return 8'd255;
        n  = grey_log2(255) - grey_log2(64'(p));
        e  = (n * 64'(g) + 64'd20) / 64'd40;
        ip = e >> Q;
        if (ip >= 40) return 8'd0;
        y = 64'd1 << Q;
        for (int i = 1; i <= Q; i++) begin
            if ((e >> (Q - i)) & 64'd1)
                y = (y * root_step[i] + (64'd1 << (Q - 1))) >> Q;
        end
        y = y >> ip;
        o = (64'd255 * y + (64'd1 << (Q - 1))) >> Q;
        return (o > 255) ? 8'd255 : o[7:0];
    endfunction

    task automatic send_pixel(input logic [7:0] p, input logic fe);
        pix_beat_t b;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            idle_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (idle_cycles > 0) begin
                s_valid <= 1'b0;
                repeat (idle_cycles) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid        <= 1'b1;
        s_pixel_in     <= p;
        s_frame_end_in <= fe;
        do @(posedge aclk); while (!s_ready);
        b.pix = gamma_map(p, cur_gamma);
        b.fe  = fe;
        pending_pix.push_back(b);
    endtask

    task automatic drain_and_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_pix.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_gamma(input logic [7:0] g);
        drain_and_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= g;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        cur_gamma = g;
        stall_mode = $urandom_range(0, 2);
    endtask

    task automatic send_random(input int n);
        for (int i = 0; i < n; i++)
            send_pixel(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0));
    endtask

    task automatic test_reset_gamma();
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd1, 1'b1);
        send_pixel(8'd128, 1'b0);
        send_pixel(8'd254, 1'b0);
        send_pixel(8'd255, 1'b1);
        send_random(60);
    endtask

    task automatic test_zero_gamma();
        set_gamma(8'd0);
        send_pixel(8'd0, 1'b1);
        send_pixel(8'd85, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_random(40);
    endtask

    task automatic test_deep_exponent();
        set_gamma(8'd255);
        send_pixel(8'd1, 1'b0);
        send_pixel(8'd2, 1'b1);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd170, 1'b1);
        send_random(60);
    endtask

    task automatic test_gamma_extremes();
        set_gamma(8'd200);
        send_pixel(8'd1, 1'b0);
        send_pixel(8'd254, 1'b1);
        send_random(50);
        set_gamma(8'd1);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd1, 1'b0);
        send_pixel(8'd254, 1'b1);
        send_random(50);
    endtask

    task automatic test_random_gamma();
        for (int k = 0; k < 4; k++) begin
            set_gamma(8'($urandom_range(0, 255)));
            send_random(60);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            case (stall_mode)
                0:       m_ready <= 1'b1;
                1:       m_ready <= ($urandom_range(0, 3) != 0);
                default: m_ready <= ($urandom_range(0, 1) == 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        pix_beat_t exp_b;
        if (aresetn && m_valid && m_ready) begin
            if (pending_pix.size() == 0) begin
                $error("unexpected output beat pixel_out=%0d", m_pixel_out);
                err_cnt++;
            end else begin
                exp_b = pending_pix.pop_front();
                if (m_pixel_out !== exp_b.pix) begin
                    $error("pixel_out expected %0d actual %0d", exp_b.pix, m_pixel_out);
                    err_cnt++;
                end
                if (m_frame_end_out !== exp_b.fe) begin
                    $error("frame_end_out expected %0d actual %0d", exp_b.fe,
                           m_frame_end_out);
                    err_cnt++;
                end
            end
        end
    end

    int wdog_cnt = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            wdog_cnt <= 0;
        end else begin
            wdog_cnt <= wdog_cnt + 1;
            if (wdog_cnt >= WDOG_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        logic [63:0] c;
        aresetn        = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        s_valid        = 1'b0;
        s_pixel_in     = '0;
        s_frame_end_in = 1'b0;
        err_cnt        = 0;
        burst_left     = 0;
        stall_mode     = 1;
        cur_gamma      = 8'd40;
        c = 64'd1 << (Q - 1);
        for (int i = 1; i <= Q; i++) begin
            c = int_sqrt(c << Q);
            root_step[i] = c;
        end
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_gamma();
        test_zero_gamma();
        test_deep_exponent();
        test_gamma_extremes();
        test_random_gamma();
        drain_and_idle();
        repeat (10) @(posedge aclk);
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
